/* hw/rtl/vfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the view-frustum culling block
// Item formats, queue entry, opcodes and sizes used by every module.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_IDX_W = 3;
  localparam int COORD_WIDTH = 32;
  localparam int CFG_COUNT   = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_BOX    = 2'd1;
  localparam logic [1:0] OP_SPHERE = 2'd2;
  localparam logic [1:0] OP_POINT  = 2'd3;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [COORD_WIDTH-1:0] pos_a_x;
    logic signed [COORD_WIDTH-1:0] pos_a_y;
    logic signed [COORD_WIDTH-1:0] pos_a_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;
    logic [30:0]                   sphere_radius;
  } in_item_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] op_done;
  } out_item_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [63:0]            thr;
  } q_entry_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef logic [CFG_COUNT-1:0][CFG_DATA_W-1:0] cfg_bank_t;

endpackage
`default_nettype wire

/* hw/rtl/view_frustum_culling_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// view_frustum_culling_top: frustum culling in Q16.16 fixed point
// Six planes from a configured view-projection matrix; box, sphere and
// point visibility tests against them.
// ----------------------------------------------------------------------------
//  channel  | ports                           | transfer when
//  ---------+---------------------------------+-------------------------
//  input    | in_valid, in_stall, in_data     | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data  | out_valid && !out_stall
//  config   | cfg_we, cfg_index, cfg_wdata    | cfg_we
//
//  A test runs in the back end as one multiply per plane component
//  through the single shared multiplier, six planes of four.
//  An update runs per plane a 32-step square root and four 48-step
//  divisions (fewer for a plane with a zero normal).
//  Reset clears the matrix and the planes; a two-entry queue lets the
//  input keep taking items while the back end or the result side stalls.
// ----------------------------------------------------------------------------
module view_frustum_culling_top import vfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_bank_t cfg_bank_r;
  q_status_t q_stat;
  q_entry_t  q_wdata, q_rdata;
  logic      q_push, q_pop;

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bank_r <= '0;
    end else if (cfg_we) begin
      cfg_bank_r[cfg_index] <= cfg_wdata;
    end
  end

  vfc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  vfc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  vfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (cfg_bank_r),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // An update always reports visible
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.op_done == OP_UPDATE) |-> out_data.visible)
    else $error("update result not visible");

  // No result straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The back end never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

/* hw/rtl/vfc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_front: input side of the culling block
// Accepts items, decodes the opcode and forms the rejection threshold.
// ----------------------------------------------------------------------------
module vfc_front import vfc_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_stat,
  output logic      q_push,
  output q_entry_t  q_wdata
);

  logic signed [63:0] rad_q;

  // Radius in Q32.32
  assign rad_q = $signed({17'd0, in_data.sphere_radius, 16'd0});

  // Hold the source while the queue is full
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // Classify: a sphere rejects below minus its radius, the rest below zero
  always_comb begin
    q_wdata.opcode = in_data.opcode;
    q_wdata.ax     = in_data.pos_a_x;
    q_wdata.ay     = in_data.pos_a_y;
    q_wdata.az     = in_data.pos_a_z;
    q_wdata.bx     = in_data.box_max_x;
    q_wdata.by     = in_data.box_max_y;
    q_wdata.bz     = in_data.box_max_z;
    case (in_data.opcode)
      OP_SPHERE: q_wdata.thr = -rad_q;
      default:   q_wdata.thr = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/vfc_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_fifo: short queue between front and back
// Lets the front take items while the back is busy with a long update.
// ----------------------------------------------------------------------------
module vfc_fifo import vfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t stat
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = count_r;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vfc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_back: execution side of the culling block
// Builds and normalises planes on update; walks the planes for tests with
// one shared multiplier, a bit-serial square root and a restoring divider.
// ----------------------------------------------------------------------------
module vfc_back import vfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_bank_t mat,
  input  q_status_t q_stat,
  output logic      q_pop,
  input  q_entry_t  q_rdata,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TEST = 4'd1;
  localparam logic [3:0] S_TEND = 4'd2;
  localparam logic [3:0] S_RAW  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [PLANE_IDX_W-1:0] PLANE_LAST = PLANE_IDX_W'(PLANE_COUNT - 1);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

  function automatic logic [31:0] sat_quot(input logic [47:0] q, input logic neg);
    if (!neg) begin
      sat_quot = (q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat_quot = (q > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
  endfunction

  logic [3:0]             state_r, state_nxt;
  logic [3:0][31:0]       plane_r [PLANE_COUNT];
  q_entry_t               item_r;
  logic [PLANE_IDX_W-1:0] pidx_r;
  logic [1:0]             k_r;
  logic                   vis_r;
  logic signed [63:0]     prod_r;
  logic                   prod_v_r, prod_first_r, prod_last_r, prod_sq_r;
  logic signed [63:0]     acc_r, acc_nxt;
  logic signed [31:0]     v_r [4];
  logic [63:0]            n_r, res_r, bit_r;
  logic [31:0]            len_r;
  logic [31:0]            rem_r;
  logic [47:0]            dvd_r, quo_r;
  logic [5:0]             cnt_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [3:0][31:0]       pl;
  logic signed [31:0]     mul_a, mul_b;
  logic signed [63:0]     dist_sum;
  logic signed [31:0]     raw [4];
  logic [63:0]            trial, n_nxt, res_nxt;
  logic [32:0]            rem_sh;
  logic                   div_ge;
  logic [47:0]            quo_nxt;
  logic                   out_free;
  logic                   last_comp, last_plane;
  logic [31:0]            vmag;

  assign pl         = plane_r[pidx_r];
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign q_pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign last_comp  = (k_r == 2'd3);
  assign last_plane = (pidx_r == PLANE_LAST);
  assign vmag       = v_r[k_r][31] ? (32'd0 - v_r[k_r]) : v_r[k_r];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TEST: begin
        mul_a = $signed(pl[k_r]);
        case (k_r)
          2'd0: mul_b = (item_r.opcode == OP_BOX && $signed(pl[0]) > 0) ?
                        item_r.bx : item_r.ax;
          2'd1: mul_b = (item_r.opcode == OP_BOX && $signed(pl[1]) > 0) ?
                        item_r.by : item_r.ay;
          2'd2: mul_b = (item_r.opcode == OP_BOX && $signed(pl[2]) > 0) ?
                        item_r.bz : item_r.az;
          default: mul_b = 32'sd65536;
        endcase
      end
      S_SQ: begin
        mul_a = v_r[k_r];
        mul_b = v_r[k_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Accumulate products: saturating for distances, plain for squares
  assign dist_sum = sat_add(acc_r, prod_r);
  always_comb begin
    if (prod_first_r) begin
      acc_nxt = prod_r;
    end else if (prod_sq_r) begin
      acc_nxt = acc_r + prod_r;
    end else begin
      acc_nxt = dist_sum;
    end
  end

  // Raw plane: row 3 plus or minus the selected row, saturated
  always_comb begin
    logic [1:0]         row;
    logic [2:0]         ridx;
    logic [2:0]         r3idx;
    logic [63:0]        rw;
    logic signed [32:0] m3, mr, s;
    row = pidx_r[2:1];
    for (int k = 0; k < 4; k++) begin
      r3idx = {k[1:0], 1'b1};
      ridx  = {k[1:0], row[1]};
      rw    = mat[ridx];
      m3    = {mat[r3idx][63], mat[r3idx][63:32]};
      mr    = row[0] ? {rw[63], rw[63:32]} : {rw[31], rw[31:0]};
      s     = pidx_r[0] ? (m3 - mr) : (m3 + mr);
      if (s[32] != s[31]) begin
        raw[k] = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        raw[k] = s[31:0];
      end
    end
  end

  // One square-root digit
  always_comb begin
    trial = res_r + bit_r;
    if (n_r >= trial) begin
      n_nxt   = n_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      n_nxt   = n_r;
      res_nxt = res_r >> 1;
    end
  end

  // One quotient bit
  assign rem_sh  = {rem_r, dvd_r[47]};
  assign div_ge  = (rem_sh >= {1'b0, len_r});
  assign quo_nxt = {quo_r[46:0], div_ge};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_rdata.opcode == OP_UPDATE) ? S_RAW : S_TEST;
        end
      end
      S_TEST: if (last_comp && last_plane) state_nxt = S_TEND;
      S_TEND: state_nxt = S_DONE;
      S_RAW:  state_nxt = S_SQ;
      S_SQ:   if (k_r == 2'd2) state_nxt = S_SQW;
      S_SQW:  state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == SQRT_LAST) state_nxt = S_DIVI;
      S_DIVI: begin
        if (len_r != '0) begin
          state_nxt = S_DIV;
        end else if (last_comp) begin
          state_nxt = last_plane ? S_DONE : S_RAW;
        end
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          if (!last_comp) begin
            state_nxt = S_DIVI;
          end else begin
            state_nxt = last_plane ? S_DONE : S_RAW;
          end
        end
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and plane store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane_r[p] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      prod_v_r <= (state_r == S_TEST) || (state_r == S_SQ);
      // Drop the result once taken, load a new one when done
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Write a normalised or unnormalised plane word
      if (state_r == S_DIVI && len_r == '0) begin
        plane_r[pidx_r][k_r] <= v_r[k_r];
      end else if (state_r == S_DIV && cnt_r == DIV_LAST) begin
        plane_r[pidx_r][k_r] <= sat_quot(quo_nxt, v_r[k_r][31]);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r       <= mul_a * mul_b;
    prod_first_r <= (k_r == 2'd0);
    prod_last_r  <= (state_r == S_TEST) && last_comp;
    prod_sq_r    <= (state_r == S_SQ);
    if (prod_v_r) begin
      acc_r <= acc_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.visible <= vis_r;
      out_data_r.op_done <= item_r.opcode;
    end
    case (state_r)
      S_IDLE: begin
        item_r <= q_rdata;
        pidx_r <= '0;
        k_r    <= '0;
        vis_r  <= 1'b1;
      end
      S_TEST: begin
        k_r <= k_r + 2'd1;
        if (last_comp) begin
          pidx_r <= pidx_r + 1'b1;
        end
      end
      S_RAW: begin
        for (int k = 0; k < 4; k++) begin
          v_r[k] <= raw[k];
        end
        k_r <= '0;
      end
      S_SQ: k_r <= k_r + 2'd1;
      S_SQW: begin
        n_r   <= acc_nxt;
        res_r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= '0;
      end
      S_SQRT: begin
        n_r   <= n_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 6'd1;
        k_r   <= '0;
        if (cnt_r == SQRT_LAST) begin
          len_r <= res_nxt[31:0];
        end
      end
      S_DIVI: begin
        rem_r <= '0;
        quo_r <= '0;
        dvd_r <= {vmag, 16'd0};
        cnt_r <= '0;
        if (len_r == '0) begin
          k_r <= k_r + 2'd1;
          if (last_comp) begin
            pidx_r <= pidx_r + 1'b1;
          end
        end
      end
      S_DIV: begin
        rem_r <= div_ge ? 32'(rem_sh - {1'b0, len_r}) : rem_sh[31:0];
        quo_r <= quo_nxt;
        dvd_r <= {dvd_r[46:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          k_r <= k_r + 2'd1;
          if (last_comp) begin
            pidx_r <= pidx_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // Clear visibility on any rejecting plane
    if (prod_v_r && prod_last_r && !prod_sq_r && (dist_sum < item_r.thr)) begin
      vis_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_view_frustum_culling_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_view_frustum_culling_top: self-checking bench of the frustum culler
// Loads view-projection matrices through the register port, derives planes
// with update items and checks box, sphere and point visibility results
// against an in-bench fixed-point plane predictor, under random idling and
// long result-side stalls.
// ----------------------------------------------------------------------------
module tb_view_frustum_culling_top;
  import vfc_pkg::*;

  localparam int  RAND_ITEMS = 1500;
  localparam int  PHASES     = 10;
  localparam real TIMEOUT_NS = 40_000_000.0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  view_frustum_culling_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  // Stimulus and expected-result stores
  in_item_t  pending_items[$];
  out_item_t expected_vis[$];

  // Predictor state: matrix words and derived planes
  logic [63:0]        matrix_regs[CFG_COUNT];
  logic signed [31:0] planes[PLANE_COUNT][4];

  int  errors = 0;
  int  n_updates = 0, n_tests = 0, n_visible = 0, n_checked = 0;
  longint cyc = 0;

  always #10 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  // ---------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint mat_word(int row, int col);
    logic [63:0] r;
    r = matrix_regs[col * 2 + (row >= 2 ? 1 : 0)];
    return (row & 1) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
  endfunction

  // Derive and normalise the six planes from the matrix
  task automatic derive_planes();
    longint v[4];
    longint unsigned sumsq, len, q, m;
    int row;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      row = p / 2;
      for (int k = 0; k < 4; k++)
        v[k] = clamp32((p & 1) ? mat_word(3, k) - mat_word(row, k)
                               : mat_word(3, k) + mat_word(row, k));
      sumsq = 0;
      for (int k = 0; k < 3; k++) sumsq += longint'(v[k] * v[k]);
      len = int_sqrt(sumsq);
      for (int k = 0; k < 4; k++) begin
        if (len != 0) begin
          m = (v[k] < 0) ? -v[k] : v[k];
          q = (m << 16) / len;
          planes[p][k] = 32'(clamp32(v[k] < 0 ? -longint'(q) : longint'(q)));
        end else begin
          planes[p][k] = 32'(v[k]);
        end
      end
    end
  endtask

  function automatic longint plane_distance(int p, longint x, longint y, longint z);
    longint d;
    d = longint'(planes[p][0]) * x;
    d = add_sat64(d, longint'(planes[p][1]) * y);
    d = add_sat64(d, longint'(planes[p][2]) * z);
    return add_sat64(d, longint'(planes[p][3]) * 65536);
  endfunction

  // Work out the visibility result of one accepted item
  task automatic predict_visibility(in_item_t it);
    out_item_t r;
    longint ax, ay, az, bx, by, bz, rad, d;
    ax = longint'(signed'(it.pos_a_x));
    ay = longint'(signed'(it.pos_a_y));
    az = longint'(signed'(it.pos_a_z));
    bx = longint'(signed'(it.box_max_x));
    by = longint'(signed'(it.box_max_y));
    bz = longint'(signed'(it.box_max_z));
    rad = longint'({33'd0, it.sphere_radius}) * 65536;
    r.visible = 1'b1;
    r.op_done = it.opcode;
    if (it.opcode == OP_UPDATE) begin
      derive_planes();
      n_updates++;
    end else begin
      n_tests++;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (it.opcode == OP_BOX) begin
          d = plane_distance(p, planes[p][0] > 0 ? bx : ax,
                             planes[p][1] > 0 ? by : ay,
                             planes[p][2] > 0 ? bz : az);
          if (d < 0) r.visible = 1'b0;
        end else if (it.opcode == OP_SPHERE) begin
          if (plane_distance(p, ax, ay, az) < -rad) r.visible = 1'b0;
        end else begin
          if (plane_distance(p, ax, ay, az) < 0) r.visible = 1'b0;
        end
      end
      if (r.visible) n_visible++;
    end
    expected_vis.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one transfer per accepted item, random gaps outside quiet window
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic     take, gap;
    in_item_t nxt;
    if (rst_n) begin
      take = in_valid && !in_stall;
      if (take) begin
        predict_visibility(in_data);
        void'(pending_items.pop_front());
      end
      if (!in_valid || take) begin
        gap = (cyc < 8000 || cyc > 14000) && ($urandom_range(99) < 17);
        if (pending_items.size() != 0 && !gap) begin
          nxt = pending_items[0];
          in_valid <= 1'b1;
          in_data  <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result transfer, with a long hold-off once
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    int        hold_cnt;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_vis.size() == 0) begin
          $error("unexpected result: visible=%0d op_done=%0d",
                 out_data.visible, out_data.op_done);
          errors++;
        end else begin
          want = expected_vis.pop_front();
          n_checked++;
          if (out_data.visible !== want.visible) begin
            $error("visible: expected %0d, actual %0d", want.visible, out_data.visible);
            errors++;
          end
          if (out_data.op_done !== want.op_done) begin
            $error("op_done: expected %0d, actual %0d", want.op_done, out_data.op_done);
            errors++;
          end
        end
      end
      if (cyc == 5000) hold_cnt = 600;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (cyc < 8000 || cyc > 14000) && ($urandom_range(99) < 17);
      end
    end else begin
      hold_cnt = 0;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  function automatic in_item_t make_item(logic [1:0] op, int ax, int ay, int az,
                                         int bx, int by, int bz, int rad);
    in_item_t it;
    it.opcode = op;
    it.pos_a_x = ax; it.pos_a_y = ay; it.pos_a_z = az;
    it.box_max_x = bx; it.box_max_y = by; it.box_max_z = bz;
    it.sphere_radius = 31'(rad);
    return it;
  endfunction

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $signed($urandom_range(0, 6 << 16)) - (3 << 16);
    if (sel < 65) return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic in_item_t rand_item();
    logic [1:0] op;
    int rsel, rad;
    op = ($urandom_range(99) < 5) ? OP_UPDATE : 2'($urandom_range(1, 3));
    rsel = $urandom_range(99);
    rad = (rsel < 60) ? $urandom_range(0, 2 << 16)
        : (rsel < 70) ? 32'h7FFF_FFFF : $urandom;
    return make_item(op, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rad);
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_vis.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= val;
    matrix_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load a matrix: 0 all max, 1 all min, 2 unit cube, else perturbed cube
  task automatic load_matrix(int kind);
    logic [31:0] w[4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        case (kind)
          0: w[r][c] = 32'h7FFF_FFFF;
          1: w[r][c] = 32'h8000_0000;
          2: w[r][c] = (r == c) ? 32'h0001_0000 : 32'h0;
          default: begin
            w[r][c] = ((r == c) ? 32'h0001_0000 : 32'h0)
                      + $urandom_range(0, 1 << 16) - (1 << 15);
            if ($urandom_range(19) == 0) w[r][c] = $urandom;
          end
        endcase
      end
    for (int c = 0; c < 4; c++) begin
      write_reg(2 * c,     {w[1][c], w[0][c]});
      write_reg(2 * c + 1, {w[3][c], w[2][c]});
    end
  endtask

  initial begin
    for (int i = 0; i < CFG_COUNT; i++) matrix_regs[i] = '0;
    for (int p = 0; p < PLANE_COUNT; p++)
      for (int k = 0; k < 4; k++) planes[p][k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Tests before any update see all-zero planes
    pending_items.push_back(make_item(OP_BOX, 32'h8000_0000, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_items.push_back(make_item(OP_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000,
      0, 0, 0, 0, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(OP_POINT, -1, -1, -1, 0, 0, 0, 0));
    // Update on the zero matrix leaves zero-normal planes unnormalised
    pending_items.push_back(make_item(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_POINT, 5 << 16, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Unit cube frustum: touching, outside and degenerate cases
    load_matrix(2);
    pending_items.push_back(make_item(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_POINT, -(1 << 16), 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_POINT, 2 << 16, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SPHERE, 2 << 16, 0, 0, 0, 0, 0, 1 << 16));
    pending_items.push_back(make_item(OP_SPHERE, 2 << 16, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SPHERE, 32'h8000_0000, 0, 0, 0, 0, 0,
      32'h7FFF_FFFF));
    pending_items.push_back(make_item(OP_BOX, -(3 << 16), -(3 << 16), -(3 << 16),
      3 << 16, 3 << 16, 3 << 16, 0));
    pending_items.push_back(make_item(OP_BOX, 2 << 16, 0, 0, 3 << 16, 1, 1, 0));
    pending_items.push_back(make_item(OP_BOX, 1 << 16, 1 << 16, 1 << 16,
      -(1 << 16), -(1 << 16), -(1 << 16), 0));
    pending_items.push_back(make_item(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_BOX, 32'h8000_0000, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    wait_idle();

    // Random phases, each on its own matrix and led by an update
    for (int ph = 0; ph < PHASES; ph++) begin
      load_matrix(ph < 2 ? ph : 3);
      pending_items.push_back(make_item(OP_UPDATE, $urandom, $urandom, $urandom,
        $urandom, $urandom, $urandom, $urandom));
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) pending_items.push_back(rand_item());
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d updates and %0d tests (%0d visible) over %0d matrices.",
             n_updates, n_tests, n_visible, PHASES + 2);
    $display("Checked %0d results, %0d mismatches.", n_checked, errors);
    if (errors == 0 && expected_vis.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
